[design/bpc_pkg.sv]
package bpc_pkg;

  localparam int DivBits = 32;

  localparam logic signed [31:0] B5Offset   = 32'sd4000;
  localparam logic [31:0]        B4Offset   = 32'd32768;
  localparam logic [15:0]        B7Scale    = 16'd50000;
  localparam logic [31:0]        P2Coef     = 32'd3038;
  localparam logic signed [31:0] P1Coef     = -32'sd7357;
  localparam logic signed [31:0] PRound     = 32'sd3791;
  localparam logic [31:0]        HalfRange  = 32'h8000_0000;

  localparam logic signed [15:0] Ac1Reset = 16'sd408;
  localparam logic signed [15:0] Ac2Reset = -16'sd72;
  localparam logic signed [15:0] Ac3Reset = -16'sd14383;
  localparam logic [15:0]        Ac4Reset = 16'd32741;
  localparam logic signed [15:0] B1Reset  = 16'sd6190;
  localparam logic signed [15:0] B2Reset  = 16'sd4;
  localparam logic [1:0]         OssReset = 2'd0;

  localparam int AddrWidth = 5;

  typedef enum logic [2:0] {
    REG_AC1 = 3'd0,
    REG_AC2 = 3'd1,
    REG_AC3 = 3'd2,
    REG_AC4 = 3'd3,
    REG_B1  = 3'd4,
    REG_B2  = 3'd5,
    REG_OSS = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic [1:0]         oss;
  } cal_t;

  // one word in flight through the divider row
  typedef struct packed {
    logic        valid;
    logic [31:0] rem;
    logic [31:0] dnd;
    logic [31:0] quo;
    logic [31:0] div;
    logic        big;
    logic        err;
  } cell_t;

endpackage

[design/bpc_if.sv]
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [18:0] raw_pressure;
  logic signed [20:0] temp_term;
  modport source (output valid, output raw_pressure, output temp_term, input ready);
  modport sink (input valid, input raw_pressure, input temp_term, output ready);
endinterface

interface bpc_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] pressure_pa;
  logic        divide_error;
  modport source (output valid, output pressure_pa, output divide_error, input ready);
  modport sink (input valid, input pressure_pa, input divide_error, output ready);
endinterface

[design/bpc_front.sv]
module bpc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  bpc_pkg::cal_t       cal,
  input  logic                in_valid,
  input  logic [18:0]         up_in,
  input  logic signed [20:0]  b5_in,
  output bpc_pkg::cell_t      cell_out
);
  import bpc_pkg::*;

  logic [5:0] v;
  logic [31:0] up1, up2, up3, up4, up5;
  logic signed [31:0] b6;
  logic signed [31:0] sq_raw, ac2b6_2, ac3b6_2;
  logic signed [31:0] sq, ac2b6_3, ac3b6_3;
  logic signed [31:0] b2sq, b1sq, ac2b6_4, ac3b6_4;
  logic signed [31:0] b3, x3b;
  logic [31:0] b4p, b7;

  logic signed [31:0] ac1_x, ac2_x, ac3_x, b1_x, b2_x, ac4_x;
  logic signed [31:0] x3a, b3_pre, x3b_sum;
  logic [15:0] b7_mul;

  assign ac1_x = 32'(cal.ac1);
  assign ac2_x = 32'(cal.ac2);
  assign ac3_x = 32'(cal.ac3);
  assign b1_x  = 32'(cal.b1);
  assign b2_x  = 32'(cal.b2);
  assign ac4_x = {16'd0, cal.ac4};

  // B3, the B4 operand and the B7 scale
  assign x3a     = (b2sq >>> 11) + (ac2b6_4 >>> 11);
  assign b3_pre  = ((ac1_x <<< 2) + x3a <<< cal.oss) + 32'sd2;
  assign x3b_sum = (ac3b6_4 >>> 13) + (b1sq >>> 16) + 32'sd2;
  assign b7_mul  = B7Scale >> cal.oss;

  // advance the stages; clear the valid flags on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      cell_out.valid <= 1'b0;
    end else if (adv) begin
      v <= {v[4:0], in_valid};
      cell_out.valid <= v[5];

      up1 <= {13'd0, up_in};
      b6  <= 32'(b5_in) - B5Offset;

      up2     <= up1;
      sq_raw  <= b6 * b6;
      ac2b6_2 <= ac2_x * b6;
      ac3b6_2 <= ac3_x * b6;

      up3     <= up2;
      sq      <= sq_raw >>> 12;
      ac2b6_3 <= ac2b6_2;
      ac3b6_3 <= ac3b6_2;

      up4     <= up3;
      b2sq    <= b2_x * sq;
      b1sq    <= b1_x * sq;
      ac2b6_4 <= ac2b6_3;
      ac3b6_4 <= ac3b6_3;

      up5 <= up4;
      // divide by four, truncating toward zero
      b3  <= (b3_pre + (b3_pre[31] ? 32'sd3 : 32'sd0)) >>> 2;
      x3b <= x3b_sum >>> 2;

      b4p <= ac4_x * (x3b + B4Offset);
      b7  <= (up5 - b3) * {16'd0, b7_mul};

      cell_out.rem <= '0;
      cell_out.quo <= '0;
      cell_out.div <= b4p >> 15;
      cell_out.big <= (b7 >= HalfRange);
      cell_out.dnd <= (b7 >= HalfRange) ? b7 : {b7[30:0], 1'b0};
      cell_out.err <= ((b4p >> 15) == 32'd0);
    end
  end

endmodule

[design/bpc_div_cell.sv]
module bpc_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  bpc_pkg::cell_t cin,
  output bpc_pkg::cell_t cout
);
  import bpc_pkg::*;

  logic [32:0] trial;
  logic        fits;

  // one restoring step: shift in a dividend bit, subtract if it fits
  assign trial = {cin.rem, cin.dnd[31]};
  assign fits  = (trial >= {1'b0, cin.div});

  // advance the word; clear the valid flag on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (adv) begin
      cout.valid <= cin.valid;
      cout.rem <= fits ? 32'(trial - {1'b0, cin.div}) : trial[31:0];
      cout.dnd <= {cin.dnd[30:0], 1'b0};
      cout.quo <= {cin.quo[30:0], fits};
      cout.div <= cin.div;
      cout.big <= cin.big;
      cout.err <= cin.err;
    end
  end

endmodule

[design/bpc_back.sv]
module bpc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  bpc_pkg::cell_t     cin,
  output logic               out_valid,
  output logic signed [31:0] out_p,
  output logic               out_err
);
  import bpc_pkg::*;

  logic [2:0] v;
  logic [2:0] err;
  logic signed [31:0] pa, pb, pc, sa, sqb, m1, m2;
  logic signed [31:0] pq, corr;

  assign pq   = cin.big ? {cin.quo[30:0], 1'b0} : cin.quo;
  assign corr = ((m1 >>> 16) + (m2 >>> 16) + PRound) >>> 4;

  // hold valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v <= {v[1:0], cin.valid};
      out_valid <= v[2];
    end
  end

  // advance the correction polynomial
  always_ff @(posedge clk) begin
    if (adv) begin
      pa  <= pq;
      sa  <= pq >>> 8;
      err[0] <= cin.err;

      pb  <= pa;
      sqb <= sa * sa;
      err[1] <= err[0];

      pc  <= pb;
      m1  <= sqb * P2Coef;
      m2  <= P1Coef * pb;
      err[2] <= err[1];

      out_p   <= err[2] ? 32'sd0 : pc + corr;
      out_err <= err[2];
    end
  end

endmodule

[design/barometric_pressure_compensation.sv]
// Throughput: one word per cycle; the 32-cell divider row and the
// multiplier stages all advance together while the output is free or taken.
// Reset (rst, synchronous): clears every valid flag and loads the
// calibration registers with their default values.
module barometric_pressure_compensation (
  input  logic                              clk,
  input  logic                              rst,
  bpc_in_if.sink                            sample,
  bpc_out_if.source                         result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpc_pkg::AddrWidth-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bpc_pkg::*;

  cal_t     cal;
  logic     adv;
  reg_idx_t widx;
  cell_t    chain [DivBits+1];

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  // write calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal.ac1 <= Ac1Reset;
      cal.ac2 <= Ac2Reset;
      cal.ac3 <= Ac3Reset;
      cal.ac4 <= Ac4Reset;
      cal.b1  <= B1Reset;
      cal.b2  <= B2Reset;
      cal.oss <= OssReset;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_AC1: cal.ac1 <= pwdata[15:0];
        REG_AC2: cal.ac2 <= pwdata[15:0];
        REG_AC3: cal.ac3 <= pwdata[15:0];
        REG_AC4: cal.ac4 <= pwdata[15:0];
        REG_B1:  cal.b1  <= pwdata[15:0];
        REG_B2:  cal.b2  <= pwdata[15:0];
        REG_OSS: cal.oss <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (widx)
      REG_AC1: prdata = 32'(cal.ac1);
      REG_AC2: prdata = 32'(cal.ac2);
      REG_AC3: prdata = 32'(cal.ac3);
      REG_AC4: prdata = {16'd0, cal.ac4};
      REG_B1:  prdata = 32'(cal.b1);
      REG_B2:  prdata = 32'(cal.b2);
      REG_OSS: prdata = {30'd0, cal.oss};
      default: prdata = '0;
    endcase
  end

  // advance the whole pipe unless the output word is stuck
  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;

  bpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cal      (cal),
    .in_valid (sample.valid),
    .up_in    (sample.raw_pressure),
    .b5_in    (sample.temp_term),
    .cell_out (chain[0])
  );

  for (genvar i = 0; i < DivBits; i++) begin : g_div
    bpc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .cin  (chain[i]),
      .cout (chain[i+1])
    );
  end

  bpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cin       (chain[DivBits]),
    .out_valid (result.valid),
    .out_p     (result.pressure_pa),
    .out_err   (result.divide_error)
  );

endmodule

[design/bpc_check.sv]
module bpc_check (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_p,
  input logic        out_err
);

  // a fresh reset leaves no word on the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // a held word keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_p) && $stable(out_err))
    else $error("stalled result word changed");

  // a zero divisor forces the pressure to zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> out_p == 32'd0)
    else $error("divide error with non-zero pressure");

  // a taken output never blocks the input
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled while output free");

endmodule

bind barometric_pressure_compensation bpc_check u_bpc_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_p     (result.pressure_pa),
  .out_err   (result.divide_error)
);
